// ===== rtl/trial_division_prime_test_defines.svh =====
// Assertion macros shared by the trial division prime test RTL.
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TDP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("trial division prime test: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define TDP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("trial division prime test: next-cycle check failed");

`endif

// ===== rtl/tdp_pkg.sv =====
// Package with the widths and state type of the trial division prime test.
`timescale 1ns / 1ps
`default_nettype none
package tdp_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int D_W        = DATA_WIDTH / 2 + 1;
    localparam int SQ_W       = DATA_WIDTH + 2;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_TEST = 3'b010,
        S_DIV  = 3'b100
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/trial_division_prime_test.sv =====
// Top level of the trial division prime test.
`timescale 1ns / 1ps
`default_nettype none
`include "trial_division_prime_test_defines.svh"
// Takes one signed number per beat when start is high and busy is low, and
// answers with one o_valid strobe that carries o_is_prime; the receiver cannot
// stall that strobe. Negative numbers, zero, one and even numbers give their
// result in the cycle after the beat. For an odd number above two, each odd
// trial divisor is handled first in S_TEST, which compares the running
// square of the divisor with the number, and then in S_DIV, where a
// one-bit-per-cycle restoring remainder unit shifts the number through.
// Busy thus stays high until a divisor leaves a zero remainder, or until
// the square of the divisor exceeds the number with no divisor found. The
// strobe comes in the same cycle as busy falls.
module trial_division_prime_test (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [tdp_pkg::DATA_WIDTH-1:0] i_number,
    output logic                                     o_valid,
    output logic                                     o_is_prime
);
    import tdp_pkg::*;

    t_state                  r_state, n_state;
    logic [DATA_WIDTH-1:0]   r_num,   n_num;
    logic [DATA_WIDTH-1:0]   r_shift, n_shift;
    logic [D_W-1:0]          r_d,     n_d;
    logic [SQ_W-1:0]         r_sq,    n_sq;
    logic [D_W-1:0]          r_rem,   n_rem;
    logic [CNT_W-1:0]        r_cnt,   n_cnt;
    logic                    r_valid, n_valid;
    logic                    r_prime, n_prime;

    logic [D_W:0]            rem_t;
    logic [D_W:0]            rem_diff;
    logic [D_W-1:0]          rem_next;
    logic                    trivial;

    assign rem_t    = {r_rem, r_shift[DATA_WIDTH-1]};
    assign rem_diff = rem_t - {1'b0, r_d};
    assign rem_next = (rem_t >= {1'b0, r_d}) ? rem_diff[D_W-1:0] : rem_t[D_W-1:0];
    assign trivial  = i_number[DATA_WIDTH-1] || !i_number[0]
                      || (i_number == DATA_WIDTH'(1));

    always_comb begin
        n_state = r_state;
        n_num   = r_num;
        n_shift = r_shift;
        n_d     = r_d;
        n_sq    = r_sq;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_valid = 1'b0;
        n_prime = r_prime;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_num = i_number;
                    n_d   = D_W'(3);
                    n_sq  = SQ_W'(9);
                    if (trivial) begin
                        n_valid = 1'b1;
                        n_prime = (i_number == DATA_WIDTH'(2));
                    end else begin
                        n_state = S_TEST;
                    end
                end
            end
            S_TEST: begin
                if (r_sq > SQ_W'(r_num)) begin
                    n_valid = 1'b1;
                    n_prime = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_shift = r_num;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_shift = r_shift << 1;
                n_rem   = rem_next;
                n_cnt   = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DATA_WIDTH - 1)) begin
                    if (rem_next == '0) begin
                        n_valid = 1'b1;
                        n_prime = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_d     = r_d + D_W'(2);
                        n_sq    = r_sq + SQ_W'({r_d, 2'b00}) + SQ_W'(4);
                        n_state = S_TEST;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num   <= n_num;
        r_shift <= n_shift;
        r_d     <= n_d;
        r_sq    <= n_sq;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        r_prime <= n_prime;
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_is_prime = r_prime;

    `TDP_ASSERT_NEXT(a_even_fast, start && !busy && !i_number[0] && (i_number != DATA_WIDTH'(2)), o_valid && !o_is_prime)
    `TDP_ASSERT_SAME(a_no_strobe_in_div, r_state == S_DIV, !o_valid)
    `TDP_ASSERT_SAME(a_strobe_idle, o_valid, r_state == S_IDLE)
    `TDP_ASSERT_SAME(a_divisor_odd, r_state == S_TEST, r_d[0])

endmodule
`default_nettype wire
